/* hw/rtl/chained_hash_table_assert.svh */
// assertion macros shared by the chained hash table rtl
`ifndef CHAINED_HASH_TABLE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CHT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("chained_hash_table: assertion failed");

// next-cycle implication, checked out of reset
`define CHT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("chained_hash_table: assertion failed");

`endif

/* hw/rtl/cht_pkg.sv */
// shared constants for the chained hash table
package cht_pkg;
    localparam int KEY_W            = 31;
    localparam int CFG_W            = 13;
    localparam int IDX_W            = 12;
    localparam int DEF_BUCKETS      = 4096;
    localparam int DEF_NODES        = 4096;
    localparam int TABLE_SIZE_RESET = 4096;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;
endpackage

/* hw/rtl/cht_ram.sv */
// generic single write port ram with registered read
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

/* hw/rtl/cht_mod.sv */
// bit-serial restoring remainder unit, one key bit per cycle
module cht_mod #(
    parameter int DW = 13
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cht_pkg::KEY_W-1:0] dividend,
    input  logic [DW-1:0]             divisor,
    output logic                      done,
    output logic [DW-1:0]             remainder
);
    import cht_pkg::*;

    localparam int CW = $clog2(KEY_W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [KEY_W-1:0] dvd_reg;
    logic [DW-1:0] div_reg;
    logic [DW-1:0] rem_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_next;

    // remainder stays below divisor, so trial is below twice the divisor
    always_comb begin
        trial    = {rem_reg, dvd_reg[KEY_W-1]};
        diff     = trial - {1'b0, div_reg};
        rem_next = (trial >= {1'b0, div_reg}) ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[KEY_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(KEY_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

/* hw/rtl/chained_hash_table.sv */
// chained hash table top level: sequencer, bucket head and node memories
//
// Input channel s_*: one transfer per operation, s_kind selects insert (0) or
// search (1) of the 31-bit s_key. Output channel m_*: exactly one transfer per
// operation, in order. An insert returns the allocated node in m_node_index, or
// m_status 1 when the node pool is full. A search returns m_found and the first
// matching node of the chain, newest first.
// cfg_wr_en / cfg_wr_data write the table size (bucket count used as modulus),
// 0 acts as 1 and values above BUCKETS act as BUCKETS; write only while idle.
// The bucket comes from a bit-serial remainder unit. An insert passes through the
// hash, head and done states, a search also walks the chain node by node, and an
// insert into a full pool goes straight to done. The next transfer can be accepted
// as soon as the result is issued, since s_ready and m_valid rise together.
// One operation is in flight at a time; s_ready is high only while idle.
// Reset: a clearing pass writes the empty marker into every bucket head, one
// bucket per cycle, with s_ready low. Node memories are not
// cleared. If m_ready is held low, the finished result waits in the output
// register and a next operation may be accepted and run up to its own result.
module chained_hash_table #(
    parameter int BUCKETS = cht_pkg::DEF_BUCKETS,
    parameter int NODES   = cht_pkg::DEF_NODES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [cht_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [cht_pkg::KEY_W-1:0] s_key,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_found,
    output logic [cht_pkg::IDX_W-1:0] m_node_index,
    output logic                      m_status
);
    import cht_pkg::*;

    `include "chained_hash_table_assert.svh"

    localparam int BW  = $clog2(BUCKETS);
    localparam int NAW = $clog2(NODES);
    localparam int NPW = NAW + 1;
    localparam int DW  = $clog2(BUCKETS + 1);
    localparam int NW  = KEY_W + NPW;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_HEAD  = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [NPW-1:0] EMPTY = NPW'(NODES);

    logic [2:0]       state_reg;
    logic [BW-1:0]    clr_cnt_reg;
    logic [CFG_W-1:0] size_cfg_reg;
    logic             kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [BW-1:0]    bucket_reg;
    logic [NPW-1:0]   nodes_used_reg;
    logic [NPW-1:0]   cur_reg;
    logic [NPW-1:0]   steps_reg;
    logic             res_found_reg;
    logic [NPW-1:0]   res_idx_reg;
    logic             res_status_reg;
    logic             m_valid_reg;
    logic             m_found_reg;
    logic [IDX_W-1:0] m_node_index_reg;
    logic             m_status_reg;

    logic [31:0]      size_wide;
    logic [DW-1:0]    eff_size;
    logic             accept;
    logic             pool_full;
    logic             mod_start;
    logic             mod_done;
    logic [DW-1:0]    mod_rem;

    logic             head_wr_en;
    logic [BW-1:0]    head_wr_addr;
    logic [NPW-1:0]   head_wr_data;
    logic             head_rd_en;
    logic [NPW-1:0]   head_rd_data;

    logic             node_wr_en;
    logic             node_rd_en;
    logic [NAW-1:0]   node_rd_addr;
    logic [NW-1:0]    node_rd_data;
    logic [KEY_W-1:0] node_rd_key;
    logic [NPW-1:0]   node_rd_next;
    logic             key_hit;
    logic             out_free;

    always_comb begin
        size_wide = 32'(size_cfg_reg);
        if (size_wide == 32'd0) begin
            eff_size = DW'(1);
        end else if (size_wide > 32'(BUCKETS)) begin
            eff_size = DW'(BUCKETS);
        end else begin
            eff_size = DW'(size_wide);
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign pool_full = (nodes_used_reg == EMPTY);
    assign mod_start = accept && !(s_kind == KIND_INSERT && pool_full);
    assign out_free  = !m_valid_reg || m_ready;

    assign node_rd_key  = node_rd_data[NW-1:NPW];
    assign node_rd_next = node_rd_data[NPW-1:0];
    assign key_hit      = (node_rd_key == key_reg);

    // head memory: clearing pass after reset, relink on insert
    always_comb begin
        head_wr_en   = 1'b0;
        head_wr_addr = clr_cnt_reg;
        head_wr_data = EMPTY;
        if (state_reg == ST_CLEAR) begin
            head_wr_en = 1'b1;
        end else if (state_reg == ST_HEAD && kind_reg == KIND_INSERT) begin
            head_wr_en   = 1'b1;
            head_wr_addr = bucket_reg;
            head_wr_data = nodes_used_reg;
        end
    end

    assign head_rd_en = (state_reg == ST_HASH) && mod_done;
    assign node_wr_en = (state_reg == ST_HEAD) && (kind_reg == KIND_INSERT);

    // chain walk reads the head's node first, then follows next links
    always_comb begin
        node_rd_en   = 1'b0;
        node_rd_addr = node_rd_next[NAW-1:0];
        if (state_reg == ST_HEAD) begin
            node_rd_en   = (kind_reg == KIND_SEARCH) && (head_rd_data < EMPTY);
            node_rd_addr = head_rd_data[NAW-1:0];
        end else if (state_reg == ST_WALK) begin
            node_rd_en = !key_hit && (node_rd_next < EMPTY) && (steps_reg != EMPTY);
        end
    end

    cht_mod #(
        .DW(DW)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (s_key),
        .divisor  (eff_size),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    cht_ram #(
        .WIDTH(NPW),
        .DEPTH(BUCKETS)
    ) u_head_ram (
        .aclk   (aclk),
        .wr_en  (head_wr_en),
        .wr_addr(head_wr_addr),
        .wr_data(head_wr_data),
        .rd_en  (head_rd_en),
        .rd_addr(mod_rem[BW-1:0]),
        .rd_data(head_rd_data)
    );

    cht_ram #(
        .WIDTH(NW),
        .DEPTH(NODES)
    ) u_node_ram (
        .aclk   (aclk),
        .wr_en  (node_wr_en),
        .wr_addr(nodes_used_reg[NAW-1:0]),
        .wr_data({key_reg, head_rd_data}),
        .rd_en  (node_rd_en),
        .rd_addr(node_rd_addr),
        .rd_data(node_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            size_cfg_reg   <= CFG_W'(TABLE_SIZE_RESET);
            nodes_used_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_cfg_reg <= cfg_wr_data;
            end
            // a finished result refills the output register in ST_DONE
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == BW'(BUCKETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        kind_reg       <= s_kind;
                        key_reg        <= s_key;
                        res_found_reg  <= 1'b0;
                        res_idx_reg    <= '0;
                        res_status_reg <= STATUS_OK;
                        if (s_kind == KIND_INSERT && pool_full) begin
                            res_status_reg <= STATUS_FULL;
                            state_reg      <= ST_DONE;
                        end else begin
                            state_reg <= ST_HASH;
                        end
                    end
                end
                ST_HASH: begin
                    if (mod_done) begin
                        bucket_reg <= mod_rem[BW-1:0];
                        state_reg  <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    if (kind_reg == KIND_INSERT) begin
                        res_idx_reg    <= nodes_used_reg;
                        nodes_used_reg <= nodes_used_reg + 1'b1;
                        state_reg      <= ST_DONE;
                    end else if (head_rd_data < EMPTY) begin
                        cur_reg   <= head_rd_data;
                        steps_reg <= NPW'(1);
                        state_reg <= ST_WALK;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_WALK: begin
                    if (key_hit) begin
                        res_found_reg <= 1'b1;
                        res_idx_reg   <= cur_reg;
                        state_reg     <= ST_DONE;
                    end else if (node_rd_en) begin
                        cur_reg   <= node_rd_next;
                        steps_reg <= steps_reg + 1'b1;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_found_reg      <= res_found_reg;
                        m_node_index_reg <= IDX_W'(32'(res_idx_reg));
                        m_status_reg     <= res_status_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_node_index = m_node_index_reg;
    assign m_status     = m_status_reg;

    // a dropped insert is only reported with the pool exhausted
    `CHT_ASSERT_NOW(a_full_drop, aclk, aresetn, m_valid && m_status == STATUS_FULL, pool_full)
    // the remainder unit finishes only while the sequencer waits for it
    `CHT_ASSERT_NOW(a_mod_done_state, aclk, aresetn, mod_done, state_reg == ST_HASH)
    // every linked insert takes exactly one node from the pool
    `CHT_ASSERT_NEXT(a_alloc_step, aclk, aresetn,
        state_reg == ST_HEAD && kind_reg == KIND_INSERT,
        nodes_used_reg == $past(nodes_used_reg) + 1'b1)
endmodule
